// File: sv/fsbc_pkg.sv
// Shared constants for the device tree structure block checker.
package fsbc_pkg;

   // Default nesting limit
   localparam int MAX_DEPTH_DEFAULT = 63;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 32;
   localparam int SKIP_W   = 33;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 32;
   localparam int PHASE_W  = 3;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   // Structure block tokens
   localparam logic [WORD_W-1:0] TOK_BEGIN_NODE = 32'd1;
   localparam logic [WORD_W-1:0] TOK_END_NODE   = 32'd2;
   localparam logic [WORD_W-1:0] TOK_PROP       = 32'd3;
   localparam logic [WORD_W-1:0] TOK_NOP        = 32'd4;
   localparam logic [WORD_W-1:0] TOK_END        = 32'd9;

   // Parser phases
   localparam logic [PHASE_W-1:0] PH_TOKEN    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_NAME     = 3'd1;
   localparam logic [PHASE_W-1:0] PH_PAD      = 3'd2;
   localparam logic [PHASE_W-1:0] PH_PLEN     = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PNAMEOFF = 3'd4;
   localparam logic [PHASE_W-1:0] PH_SKIP     = 3'd5;
   localparam logic [PHASE_W-1:0] PH_DONE     = 3'd6;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CORRUPT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd2;

endpackage

// File: sv/fdt_structure_block_checker.sv
// Streaming checker for the structure block of a flattened device tree.
// The status word is registered: it appears on rsp in the cycle after the deciding byte is accepted.
// Throughput: one byte per cycle; the parser state updates in a single pass each cycle.
// The only stall comes from a full result register that the sink does not drain.
// Reset (synchronous, active high) returns the parser to token alignment at position
// zero, depth zero, and drops any pending result word.
module fdt_structure_block_checker
   import fsbc_pkg::*;
#(
   parameter int MAX_DEPTH = MAX_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // input stream: one byte of the structure block per word
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // final byte of the block
   // result stream: one status per block
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [1:0] status, [33:2] decision_offset, rest 0
);

   // Depth counter only needs to reach MAX_DEPTH
   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);

   // Parser state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [SKIP_W-1:0]  skip_ff, skip_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [POS_W-1:0]   position_ff;

   // Result register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [POS_W-1:0]    rsp_offset_ff;

   logic                accept;
   logic [BYTE_W-1:0]   data_byte;
   logic [1:0]          byte_in_word;
   logic                word_end;
   logic [WORD_W-1:0]   shifted;
   logic                verdict_valid;
   logic [STATUS_W-1:0] verdict;
   logic [SKIP_W-1:0]   skip_dec;

   // Take a new byte whenever the result register is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign data_byte    = req_tdata[BYTE_W-1:0];
   // Byte lane within the current 4-byte word tracks the stream position
   assign byte_in_word = position_ff[1:0];
   assign word_end     = (byte_in_word == 2'd3);
   assign shifted      = {word_ff[WORD_W-BYTE_W-1:0], data_byte};
   assign skip_dec     = skip_ff - SKIP_W'(1);

   always_comb begin
      phase_in      = phase_ff;
      word_in       = word_ff;
      skip_in       = skip_ff;
      depth_in      = depth_ff;
      verdict_valid = 1'b0;
      verdict       = ST_OK;

      case (phase_ff)
         PH_TOKEN: begin
            word_in = shifted;
            if (word_end) begin
               word_in = '0;
               case (shifted)
                  TOK_BEGIN_NODE: begin
                     if (depth_ff >= DEPTH_LIMIT) begin
                        verdict_valid = 1'b1;
                        verdict       = ST_CORRUPT;
                     end else begin
                        depth_in = depth_ff + DEPTH_W'(1);
                        phase_in = PH_NAME;
                     end
                  end
                  TOK_END_NODE: begin
                     if (depth_ff == '0) begin
                        verdict_valid = 1'b1;
                        verdict       = ST_CORRUPT;
                     end else begin
                        depth_in = depth_ff - DEPTH_W'(1);
                     end
                  end
                  TOK_PROP: begin
                     phase_in = PH_PLEN;
                  end
                  TOK_NOP: begin
                  end
                  TOK_END: begin
                     verdict_valid = 1'b1;
                     verdict       = (depth_ff == '0) ? ST_OK : ST_CORRUPT;
                  end
                  default: begin
                     verdict_valid = 1'b1;
                     verdict       = ST_CORRUPT;
                  end
               endcase
            end
         end
         PH_NAME: begin
            // Name ends at NUL; pad out to the word boundary if needed
            if (data_byte == '0) begin
               phase_in = word_end ? PH_TOKEN : PH_PAD;
            end
         end
         PH_PAD: begin
            if (word_end) begin
               phase_in = PH_TOKEN;
            end
         end
         PH_PLEN: begin
            word_in = shifted;
            if (word_end) begin
               phase_in = PH_PNAMEOFF;
            end
         end
         PH_PNAMEOFF: begin
            // Name offset is ignored; round the data length up to whole words
            if (word_end) begin
               skip_in  = ({1'b0, word_ff} + SKIP_W'(3)) & ~SKIP_W'(3);
               word_in  = '0;
               phase_in = (word_ff == '0) ? PH_TOKEN : PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (skip_ff != '0) begin
               skip_in = skip_dec;
            end
            if (skip_ff == '0 || skip_dec == '0) begin
               phase_in = PH_TOKEN;
            end
         end
         default: begin
         end
      endcase

      // Block ends before a decision: partial token is corrupt, else truncated
      if (!verdict_valid && req_tlast && phase_ff != PH_DONE) begin
         verdict_valid = 1'b1;
         verdict = (phase_in == PH_TOKEN && !word_end) ? ST_CORRUPT : ST_TRUNCATED;
      end

      if (verdict_valid) begin
         phase_in = PH_DONE;
      end
   end

   // Parser state: clear on reset and after the final byte of each block
   always_ff @(posedge clock) begin
      if (reset || (accept && req_tlast)) begin
         phase_ff    <= PH_TOKEN;
         word_ff     <= '0;
         skip_ff     <= '0;
         depth_ff    <= '0;
         position_ff <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         word_ff     <= word_in;
         skip_ff     <= skip_in;
         depth_ff    <= depth_in;
         position_ff <= position_ff + POS_W'(1);
      end
   end

   // Result register: load on a decision, drop once the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && verdict_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && verdict_valid) begin
         rsp_status_ff <= verdict;
         rsp_offset_ff <= position_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-STATUS_W-POS_W)'(0), rsp_offset_ff, rsp_status_ff};

   // Depth never passes the configured limit
   assert property (@(posedge clock) disable iff (reset) depth_ff <= DEPTH_LIMIT)
      else $error("nesting depth above limit");

   // Skip phase always has bytes left to drop
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> skip_ff != '0)
      else $error("skip phase with zero count");

   // Final byte returns the parser to the start of a new block
   assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> phase_ff == PH_TOKEN && position_ff == '0 && depth_ff == '0)
      else $error("state not cleared after final byte");

   // Token phase holds a partial word only mid-word
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TOKEN && byte_in_word == 2'd0 |-> word_ff == '0)
      else $error("stale token bytes at word boundary");

   // Final byte not yet decided always produces a result
   assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast && phase_ff != PH_DONE |=> rsp_valid_ff)
      else $error("missing status at end of block");

endmodule
